/* hdl/hse_pkg.sv */
// Shared constants and SHA-256 helper functions for the HMAC-SHA256 engine.
package hse_pkg;

   localparam int NUM_KEY_REGS = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int KEY_REG_W    = 64;
   localparam int MAC_W        = 256;

   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5c;
   localparam logic [7:0] PAD_MARK  = 8'h80;
   // outer message length: one key block plus the 32-byte inner digest, in bits
   localparam logic [31:0] OUTER_LEN_BITS = 32'd768;

   typedef logic [31:0] word_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sig0(input word_type x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sig0(input word_type x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* hdl/hmac_sha256_engine_unit.sv */
// HMAC-SHA256 engine: byte stream in, 256-bit MAC out, one shared SHA-256 round unit.
//
// Streams a message one byte per req word (tdata = byte, tuser = byte valid, tlast = end of
// message) and returns the HMAC-SHA256 tag as one rsp word when the tlast word is done. The
// 64-byte key lives in eight 64-bit csr registers, big-endian, zero padded; write them only
// while the block is idle. Every SHA-256 block runs through one round unit: a load state,
// the round state and a fold of the result into the chaining value. A byte that closes a
// block also runs a compression before the next word is accepted. The first word of a
// message adds one compression for the key XOR 0x36 block. The tlast word adds three
// compressions (four when fewer than 9 bytes of room remain in the final block) plus a
// hand-off of the tag to the rsp register, which holds it until taken while the block
// already accepts the next message; if the previous tag is still waiting there, the
// hand-off waits until it is taken. req_tready is high only in the idle state, so it is
// low while the round unit is busy.
module hmac_sha256_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   // csr write port, register i at index i
   input  logic                              csr_we,
   input  logic [hse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hse_pkg::KEY_REG_W-1:0]     csr_data,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] msg_byte
   input  logic                              req_tuser,   // [0] has_byte
   input  logic                              req_tlast,   // last_item
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hse_pkg::MAC_W-1:0]         rsp_tdata    // mac_word_0..3, word 0 lowest
);
   import hse_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BYTE  = 3'd1;  // store the byte, maybe close a block
   localparam logic [2:0] ST_TAIL  = 3'd2;  // end of message check
   localparam logic [2:0] ST_LOAD  = 3'd3;  // load schedule window and working vars
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_ADD   = 3'd5;  // fold into chaining value, dispatch
   localparam logic [2:0] ST_OUT   = 3'd6;

   // which block the round unit is working on
   localparam logic [2:0] PH_IPAD  = 3'd0;
   localparam logic [2:0] PH_MSG   = 3'd1;
   localparam logic [2:0] PH_PAD1  = 3'd2;
   localparam logic [2:0] PH_PAD2  = 3'd3;
   localparam logic [2:0] PH_OPAD  = 3'd4;
   localparam logic [2:0] PH_OUTER = 3'd5;

   logic [KEY_REG_W-1:0] key_ff [NUM_KEY_REGS];

   logic [2:0]  state_ff, state_in;
   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        started_ff, started_in;
   logic [63:0] count_ff, count_in;

   // item latched at accept
   logic [7:0]  byte_ff;
   logic        has_ff;
   logic        last_ff;

   // message buffer: 16 full words plus the word being gathered
   word_type    buf_ff [16];
   word_type    acc_ff;

   word_type    h_ff [8];
   word_type    inner_ff [8];
   word_type    w_ff [16];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, hh_ff;

   logic               rsp_tvalid_ff;
   logic [MAC_W-1:0]   rsp_tdata_ff;

   word_type    blk [16];
   word_type    t1, t2, w_new;
   logic [63:0] len_bits;
   logic [5:0]  pos;
   logic        req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign pos = count_ff[5:0];
   // (byte_count + 64) * 8, modulo 2^64
   assign len_bits = {count_ff[60:0] + 61'd64, 3'b000};

   // block presented to the round unit
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         blk[j] = '0;
         case (phase_ff)
            PH_IPAD: begin
               blk[j] = (j[0] ? key_ff[j/2][31:0] : key_ff[j/2][63:32]) ^ {4{IPAD_BYTE}};
            end
            PH_OPAD: begin
               blk[j] = (j[0] ? key_ff[j/2][31:0] : key_ff[j/2][63:32]) ^ {4{OPAD_BYTE}};
            end
            PH_MSG: begin
               blk[j] = buf_ff[j];
            end
            PH_PAD1: begin
               if (j < 32'(pos[5:2])) begin
                  blk[j] = buf_ff[j];
               end else if (j == 32'(pos[5:2])) begin
                  case (pos[1:0])
                     2'd0:    blk[j] = {PAD_MARK, 24'h0};
                     2'd1:    blk[j] = {acc_ff[31:24], PAD_MARK, 16'h0};
                     2'd2:    blk[j] = {acc_ff[31:16], PAD_MARK, 8'h0};
                     default: blk[j] = {acc_ff[31:8], PAD_MARK};
                  endcase
               end
               // length fits behind the marker only below byte 56
               if (pos < 6'd56) begin
                  if (j == 14) blk[j] = len_bits[63:32];
                  if (j == 15) blk[j] = len_bits[31:0];
               end
            end
            PH_PAD2: begin
               if (j == 14) blk[j] = len_bits[63:32];
               if (j == 15) blk[j] = len_bits[31:0];
            end
            PH_OUTER: begin
               if (j < 8) blk[j] = inner_ff[j%8];
               else if (j == 8) blk[j] = {PAD_MARK, 24'h0};
               else if (j == 15) blk[j] = OUTER_LEN_BITS;
            end
            default: blk[j] = '0;
         endcase
      end
   end

   // shared round unit
   always_comb begin
      t1 = hh_ff + big_sig1(e_ff) + ((e_ff & f_ff) ^ (~e_ff & g_ff)) + ROUND_K[rnd_ff]
         + w_ff[0];
      t2 = big_sig0(a_ff) + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      w_new = w_ff[0] + small_sig0(w_ff[1]) + w_ff[9] + small_sig1(w_ff[14]);
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      rnd_in     = rnd_ff;
      started_in = started_ff;
      count_in   = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!started_ff) begin
                  started_in = 1'b1;
                  count_in   = '0;
                  phase_in   = PH_IPAD;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            state_in = ST_TAIL;
            if (has_ff) begin
               count_in = count_ff + 64'd1;
               if (pos == 6'd63) begin
                  phase_in = PH_MSG;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_TAIL: begin
            if (last_ff) begin
               phase_in = PH_PAD1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_LOAD;
            case (phase_ff)
               PH_IPAD:  state_in = ST_BYTE;
               PH_MSG:   state_in = ST_TAIL;
               PH_PAD1:  phase_in = (pos < 6'd56) ? PH_OPAD : PH_PAD2;
               PH_PAD2:  phase_in = PH_OPAD;
               PH_OPAD:  phase_in = PH_OUTER;
               PH_OUTER: state_in = ST_OUT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               started_in = 1'b0;
               count_in   = '0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_IPAD;
         rnd_ff        <= '0;
         started_ff    <= 1'b0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_KEY_REGS; i++) key_ff[i] <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         rnd_ff     <= rnd_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         if (csr_we) key_ff[csr_index] <= csr_data;
         if (state_ff == ST_IDLE && req_acc && !started_ff) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
         end
         if (state_ff == ST_ADD) begin
            if (phase_ff == PH_PAD2 || (phase_ff == PH_PAD1 && pos < 6'd56)) begin
               // inner digest done: park it, restart chaining for the outer hash
               for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
            end else begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               h_ff[5] <= h_ff[5] + f_ff;
               h_ff[6] <= h_ff[6] + g_ff;
               h_ff[7] <= h_ff[7] + hh_ff;
            end
         end
         if (state_ff == ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
            for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         byte_ff <= req_tdata;
         has_ff  <= req_tuser;
         last_ff <= req_tlast;
      end
      if (state_ff == ST_BYTE && has_ff) begin
         case (pos[1:0])
            2'd0:    acc_ff[31:24] <= byte_ff;
            2'd1:    acc_ff[23:16] <= byte_ff;
            2'd2:    acc_ff[15:8]  <= byte_ff;
            default: acc_ff[7:0]   <= byte_ff;
         endcase
         if (pos[1:0] == 2'd3) buf_ff[pos[5:2]] <= {acc_ff[31:8], byte_ff};
      end
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk[i];
         a_ff  <= h_ff[0];
         b_ff  <= h_ff[1];
         c_ff  <= h_ff[2];
         d_ff  <= h_ff[3];
         e_ff  <= h_ff[4];
         f_ff  <= h_ff[5];
         g_ff  <= h_ff[6];
         hh_ff <= h_ff[7];
      end
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         hh_ff <= g_ff;
         g_ff  <= f_ff;
         f_ff  <= e_ff;
         e_ff  <= d_ff + t1;
         d_ff  <= c_ff;
         c_ff  <= b_ff;
         b_ff  <= a_ff;
         a_ff  <= t1 + t2;
      end
      if (state_ff == ST_ADD &&
          (phase_ff == PH_PAD2 || (phase_ff == PH_PAD1 && pos < 6'd56))) begin
         inner_ff[0] <= h_ff[0] + a_ff;
         inner_ff[1] <= h_ff[1] + b_ff;
         inner_ff[2] <= h_ff[2] + c_ff;
         inner_ff[3] <= h_ff[3] + d_ff;
         inner_ff[4] <= h_ff[4] + e_ff;
         inner_ff[5] <= h_ff[5] + f_ff;
         inner_ff[6] <= h_ff[6] + g_ff;
         inner_ff[7] <= h_ff[7] + hh_ff;
      end
      if (state_ff == ST_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         for (int k = 0; k < 4; k++) rsp_tdata_ff[64*k +: 64] <= {h_ff[2*k], h_ff[2*k+1]};
      end
   end

   // a fresh message always starts with the ipad compression
   a_ipad_first: assert property (@(posedge clock) disable iff (reset)
      req_acc && !started_ff |=> state_ff == ST_LOAD && phase_ff == PH_IPAD)
      else $error("ipad block not started");

   // a tag appears only out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside output state");

   // rounds end exactly at 63
   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && rnd_ff == 6'd63 |=> state_ff == ST_ADD)
      else $error("round counter out of step");

   // message is started whenever bytes are handled
   a_started: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BYTE |-> started_ff)
      else $error("byte handled before start");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the HMAC-SHA256 engine: directed and random byte streams against a local MAC model.
module tb_top;
   import hse_pkg::*;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       has_byte;
      logic       last_item;
   } msg_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [KEY_REG_W-1:0]  csr_data  = '0;

   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;

   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [MAC_W-1:0] rsp_tdata;

   hmac_sha256_engine_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // MAC model state: key copy, inner hash chain, partial block, byte counter
   // ---------------------------------------------------------------------------------------
   logic [63:0]  key_copy [NUM_KEY_REGS];
   logic [255:0] inner_chain;
   logic [511:0] part_block;     // byte 0 in the top bits
   logic [63:0]  msg_len;
   logic         in_message;

   msg_word_type pending_words[$];
   logic [255:0] mac_queue[$];    // expected tags, {mac_word_3 .. mac_word_0}
   int           fail_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         long_hold = 1'b0;
   int           hold_count = 0;
   int           word_total = 0;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one SHA-256 compression, chaining value h0 in the top bits
   function automatic logic [255:0] sha_block(input logic [255:0] hin, input logic [511:0] blk);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      logic [255:0] hout;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hin[255 - 32*i -: 32];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hout[255 - 32*i -: 32] = hin[255 - 32*i -: 32] + v[i];
      return hout;
   endfunction

   function automatic logic [255:0] init_chain();
      logic [255:0] h;
      for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] = INIT_H[i];
      return h;
   endfunction

   function automatic logic [511:0] padded_key(input logic [7:0] pad);
      logic [511:0] k;
      for (int i = 0; i < 8; i++) k[511 - 64*i -: 64] = key_copy[i];
      return k ^ {64{pad}};
   endfunction

   // advance the model by one accepted word; pushes a tag on tlast
   task automatic absorb_word(input msg_word_type mw);
      logic [5:0]   pos;
      logic [255:0] outer;
      logic [511:0] blk;
      if (!in_message) begin
         inner_chain = sha_block(init_chain(), padded_key(IPAD_BYTE));
         msg_len = '0;
         in_message = 1'b1;
      end
      if (mw.has_byte) begin
         part_block[511 - 8*msg_len[5:0] -: 8] = mw.msg_byte;
         msg_len = msg_len + 1;
         if (msg_len[5:0] == 6'd0) inner_chain = sha_block(inner_chain, part_block);
      end
      if (mw.last_item) begin
         pos = msg_len[5:0];
         part_block[511 - 8*pos -: 8] = PAD_MARK;
         for (int i = pos + 1; i < 64; i++) part_block[511 - 8*i -: 8] = 8'h00;
         if (pos >= 56) begin
            inner_chain = sha_block(inner_chain, part_block);
            part_block = '0;
         end
         // length field wraps mod 2^64, ipad block counted in
         part_block[63:0] = (msg_len + 64'd64) << 3;
         inner_chain = sha_block(inner_chain, part_block);
         outer = sha_block(init_chain(), padded_key(OPAD_BYTE));
         blk = {inner_chain, PAD_MARK, 184'd0, 32'd0, OUTER_LEN_BITS};
         outer = sha_block(outer, blk);
         // mac_word_0 = bytes 0..7 lands in the low 64 bits of tdata
         mac_queue.push_back({outer[63:0], outer[127:64], outer[191:128], outer[255:192]});
         in_message = 1'b0;
         msg_len = '0;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // request driver: one NBA per signal per edge, model updated on the accept edge
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      msg_word_type mw;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_word('{msg_byte: req_tdata, has_byte: req_tuser, last_item: req_tlast});
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               mw = pending_words.pop_front();
               req_tdata  <= mw.msg_byte;
               req_tuser  <= mw.has_byte;
               req_tlast  <= mw.last_item;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response receiver: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold && hold_count < 3000) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // tag checker
   always @(posedge clock) begin
      logic [255:0] exp_mac;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mac_queue.size() == 0) begin
            $display("%0t: unexpected tag, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            exp_mac = mac_queue.pop_front();
            for (int k = 0; k < 4; k++)
               if (rsp_tdata[64*k +: 64] !== exp_mac[64*k +: 64]) begin
                  $display("%0t: mac_word_%0d expected %h actual %h", $time, k,
                           exp_mac[64*k +: 64], rsp_tdata[64*k +: 64]);
                  fail_count++;
               end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------------
   task automatic queue_word(input logic [7:0] b, input logic hb, input logic lst);
      pending_words.push_back('{msg_byte: b, has_byte: hb, last_item: lst});
      word_total++;
   endtask

   // message of len bytes; occasional idle words inside; tlast rides the final byte or
   // comes as an empty word
   task automatic queue_message(input int len);
      logic with_byte;
      with_byte = (len > 0) && $urandom_range(1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) queue_word(8'($urandom), 1'b0, 1'b0);
         queue_word(8'($urandom), 1'b1, with_byte && (i == len - 1));
      end
      if (!with_byte) queue_word(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(12);
      if (r < 85) return $urandom_range(54, 66);   // around the padding split
      if (r < 95) return $urandom_range(118, 130); // around the two-block boundary
      return $urandom_range(190, 200);
   endfunction

   task automatic write_key(input int idx, input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_data  <= val;
      key_copy[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // all words sent and all tags back, then room for a compression still in flight
   task automatic wait_drained();
      while (pending_words.size() > 0 || req_tvalid || mac_queue.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // last message of a batch is cut short so the batch stays near its word budget
   task automatic run_random(input int n_words);
      int goal;
      int len;
      goal = word_total + n_words;
      while (word_total < goal) begin
         len = pick_length();
         if (len > goal - word_total) len = goal - word_total;
         queue_message(len);
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_KEY_REGS; i++) key_copy[i] = '0;
      inner_chain = '0;
      part_block  = '0;
      msg_len     = '0;
      in_message  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, all-zero key from reset
      queue_word(8'h00, 1'b0, 1'b1);            // empty message
      queue_word(8'hff, 1'b0, 1'b0);            // idle word starts a message
      queue_word(8'h00, 1'b1, 1'b0);
      queue_word(8'hff, 1'b1, 1'b1);            // byte carried with tlast
      queue_word(8'h80, 1'b1, 1'b1);            // one-byte message
      wait_drained();
      for (int i = 0; i < NUM_KEY_REGS; i++) write_key(i, '1);
      queue_word(8'h61, 1'b1, 1'b0);
      queue_word(8'h62, 1'b1, 1'b0);
      queue_word(8'h63, 1'b1, 1'b0);            // message left open
      wait_drained();
      // key change mid-message: the outer pad takes the new key
      for (int i = 0; i < NUM_KEY_REGS; i++) write_key(i, {$urandom, $urandom});
      queue_word(8'h00, 1'b0, 1'b1);
      queue_message(55);
      queue_message(56);
      wait_drained();

      // phase 1: no idling, short key zero padded
      write_key(0, {$urandom, $urandom});
      write_key(1, {$urandom, 32'h0});
      for (int i = 2; i < NUM_KEY_REGS; i++) write_key(i, '0);
      run_random(80);
      wait_drained();

      // phase 2: sender mostly idle, full random key; sender pause in the middle
      send_idle_pct = 82;
      for (int i = 0; i < NUM_KEY_REGS; i++) write_key(i, {$urandom, $urandom});
      run_random(40);
      wait_drained();
      run_random(40);
      wait_drained();

      // phase 3: receiver stalls, long hold-off with short messages backing up the engine
      send_idle_pct  = 0;
      recv_stall_pct = 82;
      long_hold = 1'b1;
      for (int i = 0; i < 8; i++) queue_message($urandom_range(3));
      while (hold_count < 3000) @(posedge clock);
      long_hold = 1'b0;
      run_random(70);
      wait_drained();

      // phase 4: both sides idle, key back to all ones
      send_idle_pct  = 18;
      recv_stall_pct = 18;
      for (int i = 0; i < NUM_KEY_REGS; i++) write_key(i, '1);
      run_random(80);
      wait_drained();

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(8 * 4000000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hse_pkg.sv
hdl/hmac_sha256_engine_unit.sv
tb/tb_top.sv
